@@ rtl/core/drrip_ship_replacement_policy_unit_assert.svh @@
// ----------------------------------------------------------------------------
// DRRIP replacement unit assertion macros
// Concurrent assertion wrappers clocked on clk. Defining ASSERT_OFF
// compiles them away.
// ----------------------------------------------------------------------------
`ifndef DRRIP_SHIP_REPLACEMENT_POLICY_UNIT_ASSERT_SVH
`define DRRIP_SHIP_REPLACEMENT_POLICY_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Property checked outside reset.
`define DRRIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define DRRIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DRRIP_ASSERT(lbl, prop, msg)
`define DRRIP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/core/drrip_pkg.sv @@
// ----------------------------------------------------------------------------
// DRRIP replacement unit package
// Request and response types, policy constants and the random generator step.
// ----------------------------------------------------------------------------
package drrip_pkg;

    // One request from the cache controller.
    typedef struct packed {
        logic        command;
        logic [10:0] set_index;
        logic [3:0]  way;
        logic [7:0]  pc_bits;
        logic        hit;
    } req_t;

    // One response to the cache controller.
    typedef struct packed {
        logic [3:0] victim_way;
        logic [1:0] insert_value;
    } rsp_t;

    // Operation applied to one set row.
    typedef struct packed {
        logic       update;
        logic [4:0] way;
        logic [1:0] value;
    } row_op_t;

    // Command codes.
    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Re-reference values.
    localparam logic [1:0] RRPV_NEAR    = 2'd0;
    localparam logic [1:0] RRPV_LONG    = 2'd2;
    localparam logic [1:0] RRPV_DISTANT = 2'd3;

    // Signature counter limits and reset value.
    localparam logic [1:0] SIG_RESET = 2'd1;
    localparam logic [1:0] SIG_MAX   = 2'd3;
    localparam logic [1:0] SIG_REUSE = 2'd2;

    // Random generator seed and the bimodal throttle width (one in 32).
    localparam logic [15:0] LFSR_SEED   = 16'hACE1;
    localparam int          BIMODAL_W   = 5;

    // One step of the Fibonacci generator, taps 16, 14, 13 and 11.
    function automatic logic [15:0] lfsr_next(input logic [15:0] l);
        logic fb;
        fb = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {fb, l[15:1]};
    endfunction

endpackage

@@ rtl/core/drrip_ship_replacement_policy_unit.sv @@
// ----------------------------------------------------------------------------
// DRRIP replacement policy unit
// Set dueling between static and bimodal insertion with signature-based
// insertion for follower sets.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over max(SETS, 2**SIG_BITS)
// addresses (2048 with the default sizes) that sets every way distant and
// every signature counter to one; no request is taken until it ends. Each
// request then reads the set row and the signature counter from their
// memories when it is accepted, and computes and writes both back in the
// write-back state. A new request is taken only after the previous one's
// write-back; a stalled response holds the unit in its write-back state until it is taken.
`include "drrip_ship_replacement_policy_unit_assert.svh"

module drrip_ship_replacement_policy_unit #(
    parameter int SETS          = 2048,
    parameter int WAYS          = 16,
    parameter int LEADER_SETS   = 64,
    parameter int SIG_BITS      = 6,
    parameter int SELECTOR_BITS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  drrip_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output drrip_pkg::rsp_t   rsp
);

    import drrip_pkg::*;

    localparam int SET_W       = $clog2(SETS);
    localparam int SIG_ENTRIES = 1 << SIG_BITS;
    localparam int CLR_DEPTH   = (SETS > SIG_ENTRIES) ? SETS : SIG_ENTRIES;
    localparam int CLR_W       = $clog2(CLR_DEPTH);
    localparam int ROW_W       = 2 * WAYS;

    localparam logic [ROW_W-1:0]         ROW_RESET = {WAYS{RRPV_DISTANT}};
    localparam logic [5:0]               WAYS_L    = 6'(WAYS);
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX   = {SELECTOR_BITS{1'b1}};
    localparam logic [SELECTOR_BITS-1:0] SEL_MID   = SEL_MAX >> 1;

    // Control states.
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [CLR_W-1:0]         clr_reg, clr_next;
    logic [SELECTOR_BITS-1:0] sel_reg, sel_next;
    logic [15:0]              lfsr_reg, lfsr_next_val;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_t                     rsp_reg, rsp_next;

    // Captured request fields.
    logic                cmd_reg;
    logic [SET_W-1:0]    set_reg;
    logic [3:0]          way_reg;
    logic                hit_reg;
    logic [SIG_BITS-1:0] sig_reg;

    logic                accept;
    logic                exec_go;
    logic                clearing;
    logic [SET_W-1:0]    set_red;
    logic [SIG_BITS-1:0] sig_idx;
    logic                way_ok;

    logic              row_we;
    logic [SET_W-1:0]  row_waddr;
    logic [ROW_W-1:0]  row_wdata;
    logic [ROW_W-1:0]  row_rdata;
    logic [ROW_W-1:0]  row_new;
    logic [3:0]        victim;
    row_op_t           row_op;

    logic                sig_we;
    logic [SIG_BITS-1:0] sig_waddr;
    logic [1:0]          sig_wdata;
    logic [1:0]          sig_rdata;
    logic [1:0]          sig_new;

    logic [1:0]          ins;

    assign clearing  = (state_reg == ST_CLEAR);
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign exec_go   = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Set index modulo SETS by binary compare and subtract, exact for indices below 8*SETS.
    always_comb
    begin
        logic [17:0] s;
        s = 18'(req.set_index);
        for (int i = 2; i >= 0; i--)
        begin
            if (s >= 18'(SETS << i))
            begin
                s = s - 18'(SETS << i);
            end
        end
        set_red = s[SET_W-1:0];
    end

    // Signature hash of the instruction address.
    always_comb
    begin
        logic [15:0] h;
        h = {8'h00, req.pc_bits ^ (req.pc_bits >> 2)};
        sig_idx = h[SIG_BITS-1:0];
    end

    // Capture the request at acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            set_reg <= set_red;
            way_reg <= req.way;
            hit_reg <= req.hit;
            sig_reg <= sig_idx;
        end
    end

    assign way_ok = {2'b00, way_reg} < WAYS_L;

    // Insertion decision, signature counter update, selector training and generator stepping.
    always_comb
    begin
        logic leader_s;
        logic leader_b;
        logic [15:0] l_new;
        leader_s      = 32'(set_reg) < 32'(LEADER_SETS);
        leader_b      = !leader_s && (32'(set_reg) < 32'(2 * LEADER_SETS));
        l_new         = lfsr_next(lfsr_reg);
        ins           = RRPV_NEAR;
        sel_next      = sel_reg;
        lfsr_next_val = lfsr_reg;
        sig_new       = sig_rdata;
        if (cmd_reg == CMD_UPDATE && way_ok)
        begin
            if (hit_reg)
            begin
                if (sig_rdata < SIG_MAX)
                begin
                    sig_new = sig_rdata + 2'd1;
                end
            end
            else
            begin
                if (leader_s)
                begin
                    ins = RRPV_LONG;
                    if (sel_reg != '0)
                    begin
                        sel_next = sel_reg - 1'b1;
                    end
                end
                else if (leader_b)
                begin
                    lfsr_next_val = l_new;
                    ins = (l_new[BIMODAL_W-1:0] == '0) ? RRPV_LONG : RRPV_DISTANT;
                    if (sel_reg != SEL_MAX)
                    begin
                        sel_next = sel_reg + 1'b1;
                    end
                end
                else if (sig_rdata >= SIG_REUSE)
                begin
                    ins = RRPV_NEAR;
                end
                else if (sel_reg >= SEL_MID)
                begin
                    ins = RRPV_LONG;
                end
                else
                begin
                    lfsr_next_val = l_new;
                    ins = (l_new[BIMODAL_W-1:0] == '0) ? RRPV_LONG : RRPV_DISTANT;
                end
                if (sig_rdata != 2'd0)
                begin
                    sig_new = sig_rdata - 2'd1;
                end
            end
        end
    end

    // Row operation for the row logic.
    always_comb
    begin
        row_op.update = (cmd_reg == CMD_UPDATE);
        row_op.way    = {1'b0, way_reg};
        row_op.value  = ins;
    end

    drrip_row_logic #(
        .WAYS (WAYS)
    ) u_row_logic (
        .row     (row_rdata),
        .op      (row_op),
        .row_new (row_new),
        .victim  (victim)
    );

    // Memory write ports: clearing pass or write-back.
    always_comb
    begin
        if (clearing)
        begin
            row_we    = 32'(clr_reg) < 32'(SETS);
            row_waddr = clr_reg[SET_W-1:0];
            row_wdata = ROW_RESET;
            sig_we    = 32'(clr_reg) < 32'(SIG_ENTRIES);
            sig_waddr = clr_reg[SIG_BITS-1:0];
            sig_wdata = SIG_RESET;
        end
        else
        begin
            row_we    = exec_go && ((cmd_reg == CMD_VICTIM) || way_ok);
            row_waddr = set_reg;
            row_wdata = row_new;
            sig_we    = exec_go && (cmd_reg == CMD_UPDATE) && way_ok;
            sig_waddr = sig_reg;
            sig_wdata = sig_new;
        end
    end

    drrip_ram #(
        .DEPTH  (SETS),
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (accept),
        .raddr (set_red),
        .rdata (row_rdata)
    );

    drrip_ram #(
        .DEPTH  (SIG_ENTRIES),
        .ADDR_W (SIG_BITS),
        .DATA_W (2)
    ) u_sig_ram (
        .clk   (clk),
        .we    (sig_we),
        .waddr (sig_waddr),
        .wdata (sig_wdata),
        .re    (accept),
        .raddr (sig_idx),
        .rdata (sig_rdata)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Response register.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (exec_go)
        begin
            rsp_valid_next = 1'b1;
            if (cmd_reg == CMD_VICTIM)
            begin
                rsp_next.victim_way   = victim;
                rsp_next.insert_value = RRPV_NEAR;
            end
            else
            begin
                rsp_next.victim_way   = '0;
                rsp_next.insert_value = ins;
            end
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control and policy state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            sel_reg       <= SEL_MID;
            lfsr_reg      <= LFSR_SEED;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_go)
            begin
                sel_reg  <= sel_next;
                lfsr_reg <= lfsr_next_val;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Checks on the sequencer and the response.
    `DRRIP_ASSERT_ALWAYS(a_no_request_in_clear, (state_reg == ST_CLEAR) |-> !req_ready, "request taken during clearing pass")
    `DRRIP_ASSERT(a_accept_to_exec, (req_valid && req_ready) |=> (state_reg == ST_EXEC), "accepted request did not start its write-back cycle")
    `DRRIP_ASSERT(a_exec_gives_rsp, exec_go |=> rsp_valid, "finished request produced no response")
    `DRRIP_ASSERT(a_write_only_in_exec, (row_we && !clearing) |-> exec_go, "row written outside a write-back cycle")
    `DRRIP_ASSERT(a_rsp_one_field, rsp_valid |-> (rsp.victim_way == '0 || rsp.insert_value == '0), "response carries both a victim and an insertion value")

endmodule

@@ rtl/core/drrip_ram.sv @@
// ----------------------------------------------------------------------------
// DRRIP generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module drrip_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port with read enable.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/drrip_row_logic.sv @@
// ----------------------------------------------------------------------------
// DRRIP set row logic
// Ages a set row and picks the victim, or writes one way's new value.
// ----------------------------------------------------------------------------
module drrip_row_logic #(
    parameter int WAYS = 16
) (
    input  logic [2*WAYS-1:0] row,
    input  drrip_pkg::row_op_t op,
    output logic [2*WAYS-1:0] row_new,
    output logic [3:0]        victim
);

    import drrip_pkg::*;

    logic [1:0] maxv;
    logic [1:0] age_add;

    // Largest re-reference value in the row.
    always_comb
    begin
        logic any3;
        logic any2;
        logic any1;
        logic [1:0] v;
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            v = row[2*w +: 2];
            any3 = any3 | (v == 2'd3);
            any2 = any2 | (v == 2'd2);
            any1 = any1 | (v == 2'd1);
        end
        if (any3)
        begin
            maxv = 2'd3;
        end
        else if (any2)
        begin
            maxv = 2'd2;
        end
        else if (any1)
        begin
            maxv = 2'd1;
        end
        else
        begin
            maxv = 2'd0;
        end
    end

    // Aging adds the same amount to every way so the largest becomes distant.
    assign age_add = RRPV_DISTANT - maxv;

    // The victim is the lowest way that held the largest value.
    always_comb
    begin
        victim = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row[2*w +: 2] == maxv)
            begin
                victim = 4'(w);
            end
        end
    end

    // New row: aged row for a victim search, one way replaced for an update.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (op.update)
            begin
                row_new[2*w +: 2] = (5'(w) == op.way) ? op.value : row[2*w +: 2];
            end
            else
            begin
                row_new[2*w +: 2] = row[2*w +: 2] + age_add;
            end
        end
    end

endmodule
